// ===== design/acz_pkg.sv =====
// Shared types, codes and default sizes for the axis convolution block.
`default_nettype none

package acz_pkg;

  // Default build sizes.
  localparam int DEFAULT_MAX_RADIUS = 8;
  localparam int DEFAULT_MAX_SIZE_X = 32;
  localparam int DEFAULT_MAX_SIZE_Y = 32;
  localparam int DEFAULT_MAX_SIZE_Z = 64;

  // Configuration port.
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 7;

  localparam logic [CFG_IW-1:0] CFG_AXIS   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_RADIUS = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SIZE_X = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_SIZE_Y = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_SIZE_Z = 3'd4;

  // Item modes.
  localparam logic [1:0] MODE_TAP   = 2'd0;
  localparam logic [1:0] MODE_VOXEL = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  // Convolution axes.
  localparam logic [1:0] AXIS_Z = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_X = 2'd2;

  // Register values after reset.
  localparam logic [1:0] AXIS_RESET   = AXIS_X;
  localparam logic [3:0] RADIUS_RESET = 4'd1;
  localparam logic [5:0] SIZE_X_RESET = 6'd32;
  localparam logic [5:0] SIZE_Y_RESET = 6'd32;
  localparam logic [6:0] SIZE_Z_RESET = 7'd64;

  // Cycles for the derived sizes to settle, and for the multiply-accumulate to drain.
  localparam int SETTLE_CYCLES = 3;
  localparam int DRAIN_CYCLES  = 2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  tap_index;
    logic [15:0] sample_value;
  } in_t;

  typedef struct packed {
    logic [15:0] out_value;
    logic        last_voxel;
  } out_t;

  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctrl_t;

  typedef enum logic [3:0] {
    S_SETTLE,
    S_DIVZ_GO,
    S_DIVZ_WAIT,
    S_DIVY_GO,
    S_DIVY_WAIT,
    S_IDLE,
    S_DECODE,
    S_WRITE,
    S_TEST,
    S_START,
    S_MAC,
    S_DRAIN,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== design/axis_convolution_zero_pad_top.sv =====
// Axis convolution with zero padding: sequencer, counters and configuration.
// A tap word passes through decode only; a voxel word also writes the ring and tests
// whether an output is due. A voxel word with a result, and a flush word, go on through
// start, the tap loop, drain and output; the shared multiply-accumulate visits one tap per cycle.
// After reset and after each configuration write the block recomputes the output
// position with a bit-serial divider.
// Reset is synchronous; the kernel reads as zero and the counters start at zero.
`default_nettype none

module axis_convolution_zero_pad_top #(
  parameter int MAX_RADIUS = acz_pkg::DEFAULT_MAX_RADIUS,
  parameter int MAX_SIZE_X = acz_pkg::DEFAULT_MAX_SIZE_X,
  parameter int MAX_SIZE_Y = acz_pkg::DEFAULT_MAX_SIZE_Y,
  parameter int MAX_SIZE_Z = acz_pkg::DEFAULT_MAX_SIZE_Z
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire acz_pkg::in_t               in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output acz_pkg::out_t                   out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [acz_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [acz_pkg::CFG_DW-1:0] cfg_data
);

  localparam int      TAP_COUNT  = 2 * MAX_RADIUS + 1;
  localparam int      TAW        = $clog2(TAP_COUNT);
  localparam int      RING_DEPTH = 2 * MAX_RADIUS * MAX_SIZE_X * MAX_SIZE_Y + 1;
  localparam int      RAW        = $clog2(RING_DEPTH);
  localparam longint  VOLUME     = longint'(MAX_SIZE_X) * longint'(MAX_SIZE_Y) *
                                   longint'(MAX_SIZE_Z);
  localparam int      CW         = $clog2(VOLUME + 1);
  localparam int      XW         = $clog2(MAX_SIZE_X + 1);
  localparam int      YW         = $clog2(MAX_SIZE_Y + 1);
  localparam int      ZW         = $clog2(MAX_SIZE_Z + 1);
  localparam int      PW         = $clog2(MAX_SIZE_X * MAX_SIZE_Y + 1);
  localparam int      RW         = $clog2(MAX_RADIUS + 1);
  localparam int      LW         = $clog2(MAX_RADIUS * MAX_SIZE_X * MAX_SIZE_Y + 1);
  localparam int      SW         = ((CW > LW) ? CW : LW) + 1;
  localparam int      RLW        = ((CW > RW) ? CW : RW) + 2;
  localparam int      AW         = 32 + TAW;
  localparam int      STW        = $clog2(acz_pkg::SETTLE_CYCLES);
  localparam int      DRW        = $clog2(acz_pkg::DRAIN_CYCLES);

  acz_pkg::state_t state;
  acz_pkg::state_t state_next;

  // Configuration registers.
  logic [1:0] cfg_axis;
  logic [3:0] cfg_radius;
  logic [5:0] cfg_size_x;
  logic [5:0] cfg_size_y;
  logic [6:0] cfg_size_z;

  // Effective configuration after clamping.
  logic [1:0]    axis_e;
  logic [XW-1:0] sx_e;
  logic [YW-1:0] sy_e;
  logic [ZW-1:0] sz_e;
  logic [RW-1:0] rad_e;

  // Derived sizes, registered.
  logic [PW-1:0] plane_q;
  logic [PW-1:0] stride_q;
  logic [LW-1:0] lag_q;
  logic [CW-1:0] total_q;

  // Stream counters and position of the next output.
  logic [CW-1:0]  inputs_seen;
  logic [CW-1:0]  outputs_sent;
  logic [RAW-1:0] in_ptr;
  logic [RAW-1:0] out_ptr;
  logic [XW-1:0]  ox;
  logic [YW-1:0]  oy;
  logic [CW-1:0]  oz;

  // Sequencer registers.
  logic [STW-1:0]         settle_cnt;
  logic [DRW-1:0]         drain_cnt;
  logic [TAW-1:0]         k;
  logic                   issue_q;
  acz_pkg::in_t           item;
  logic [RAW-1:0]         addr;
  logic signed [RLW-1:0]  rel;

  // Combinational helpers.
  logic              in_acc;
  logic              cfg_acc;
  logic [CW-1:0]     pos_c;
  logic [CW-1:0]     len_c;
  logic              tap_ok;
  logic              emit_test;
  logic              flush_ok;
  logic              issue_v;
  logic              out_load;
  logic              last_c;
  logic [RAW:0]      base_c;
  logic [RAW:0]      step_c;
  logic [RAW-1:0]    base_addr;
  logic [RAW-1:0]    step_addr;

  // Shared units.
  logic              div_start;
  logic [CW-1:0]     div_dividend;
  logic [PW-1:0]     div_divisor;
  logic              div_done;
  logic [CW-1:0]     div_quotient;
  logic [PW-1:0]     div_remainder;
  acz_pkg::mac_ctrl_t mac_ctrl;
  logic [15:0]       mac_result;
  logic              ring_we;
  logic              tap_we;
  logic [15:0]       ring_rdata;
  logic [15:0]       tap_rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != acz_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // Clamp the registers to the ranges the hardware supports.
  always_comb begin
    axis_e = (cfg_axis > acz_pkg::AXIS_X) ? acz_pkg::AXIS_X : cfg_axis;
    if (cfg_size_x == '0) begin
      sx_e = XW'(1);
    end else if (32'(cfg_size_x) > MAX_SIZE_X) begin
      sx_e = XW'(MAX_SIZE_X);
    end else begin
      sx_e = XW'(cfg_size_x);
    end
    if (cfg_size_y == '0) begin
      sy_e = YW'(1);
    end else if (32'(cfg_size_y) > MAX_SIZE_Y) begin
      sy_e = YW'(MAX_SIZE_Y);
    end else begin
      sy_e = YW'(cfg_size_y);
    end
    if (cfg_size_z == '0) begin
      sz_e = ZW'(1);
    end else if (32'(cfg_size_z) > MAX_SIZE_Z) begin
      sz_e = ZW'(MAX_SIZE_Z);
    end else begin
      sz_e = ZW'(cfg_size_z);
    end
    if (32'(cfg_radius) > MAX_RADIUS) begin
      rad_e = RW'(MAX_RADIUS);
    end else begin
      rad_e = RW'(cfg_radius);
    end
  end

  // Position of the current output along the axis, and the axis length.
  always_comb begin
    case (axis_e)
      acz_pkg::AXIS_Z: begin
        pos_c = oz;
        len_c = CW'(sz_e);
      end
      acz_pkg::AXIS_Y: begin
        pos_c = CW'(oy);
        len_c = CW'(sy_e);
      end
      default: begin
        pos_c = CW'(ox);
        len_c = CW'(sx_e);
      end
    endcase
  end

  // Decisions taken on the counters.
  always_comb begin
    tap_ok    = (32'(item.tap_index) < TAP_COUNT);
    emit_test = (outputs_sent < total_q) &&
                (SW'(inputs_seen) > (SW'(outputs_sent) + SW'(lag_q)));
    flush_ok  = (inputs_seen >= total_q) && (outputs_sent < total_q);
    last_c    = (({1'b0, outputs_sent} + (CW + 1)'(1)) == {1'b0, total_q});
    out_load  = (state == acz_pkg::S_OUT) && (!out_valid || !out_stall);
    ring_we   = (state == acz_pkg::S_WRITE) && (inputs_seen < total_q);
    tap_we    = (state == acz_pkg::S_DECODE) && (item.mode == acz_pkg::MODE_TAP) && tap_ok;
    issue_v   = (state == acz_pkg::S_MAC) && !rel[RLW-1] &&
                (rel[RLW-2:0] < (RLW - 1)'(len_c));
  end

  // Ring addresses: first neighbour of the output, then one stride per tap.
  always_comb begin
    if ({1'b0, out_ptr} >= (RAW + 1)'(lag_q)) begin
      base_c = {1'b0, out_ptr} - (RAW + 1)'(lag_q);
    end else begin
      base_c = {1'b0, out_ptr} + (RAW + 1)'(RING_DEPTH) - (RAW + 1)'(lag_q);
    end
    base_addr = RAW'(base_c);
    step_c    = {1'b0, addr} + (RAW + 1)'(stride_q);
    if (step_c >= (RAW + 1)'(RING_DEPTH)) begin
      step_addr = RAW'(step_c - (RAW + 1)'(RING_DEPTH));
    end else begin
      step_addr = RAW'(step_c);
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acz_pkg::S_SETTLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit controls.
  always_comb begin
    state_next     = state;
    div_start      = 1'b0;
    div_dividend   = outputs_sent;
    div_divisor    = plane_q;
    mac_ctrl.clear = (state == acz_pkg::S_START);
    mac_ctrl.en    = issue_q;
    case (state)
      acz_pkg::S_SETTLE: begin
        if (settle_cnt == '0) begin
          state_next = acz_pkg::S_DIVZ_GO;
        end
      end
      acz_pkg::S_DIVZ_GO: begin
        div_start  = 1'b1;
        state_next = acz_pkg::S_DIVZ_WAIT;
      end
      acz_pkg::S_DIVZ_WAIT: begin
        if (div_done) begin
          state_next = acz_pkg::S_DIVY_GO;
        end
      end
      acz_pkg::S_DIVY_GO: begin
        div_start    = 1'b1;
        div_dividend = CW'(div_remainder);
        div_divisor  = PW'(sx_e);
        state_next   = acz_pkg::S_DIVY_WAIT;
      end
      acz_pkg::S_DIVY_WAIT: begin
        if (div_done) begin
          state_next = acz_pkg::S_IDLE;
        end
      end
      acz_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = acz_pkg::S_DECODE;
        end
      end
      acz_pkg::S_DECODE: begin
        case (item.mode)
          acz_pkg::MODE_VOXEL: state_next = acz_pkg::S_WRITE;
          acz_pkg::MODE_FLUSH: state_next = flush_ok ? acz_pkg::S_START : acz_pkg::S_IDLE;
          default:             state_next = acz_pkg::S_IDLE;
        endcase
      end
      acz_pkg::S_WRITE: begin
        state_next = acz_pkg::S_TEST;
      end
      acz_pkg::S_TEST: begin
        state_next = emit_test ? acz_pkg::S_START : acz_pkg::S_IDLE;
      end
      acz_pkg::S_START: begin
        state_next = acz_pkg::S_MAC;
      end
      acz_pkg::S_MAC: begin
        if (k == TAW'({rad_e, 1'b0})) begin
          state_next = acz_pkg::S_DRAIN;
        end
      end
      acz_pkg::S_DRAIN: begin
        if (drain_cnt == DRW'(acz_pkg::DRAIN_CYCLES - 1)) begin
          state_next = acz_pkg::S_OUT;
        end
      end
      acz_pkg::S_OUT: begin
        if (out_load) begin
          state_next = acz_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = acz_pkg::S_SETTLE;
      end
    endcase
    // A configuration write always restarts the settle sequence.
    if (cfg_acc) begin
      state_next = acz_pkg::S_SETTLE;
    end
  end

  // Control registers: configuration, counters and sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_axis     <= acz_pkg::AXIS_RESET;
      cfg_radius   <= acz_pkg::RADIUS_RESET;
      cfg_size_x   <= acz_pkg::SIZE_X_RESET;
      cfg_size_y   <= acz_pkg::SIZE_Y_RESET;
      cfg_size_z   <= acz_pkg::SIZE_Z_RESET;
      inputs_seen  <= '0;
      outputs_sent <= '0;
      in_ptr       <= '0;
      out_ptr      <= '0;
      ox           <= '0;
      oy           <= '0;
      oz           <= '0;
      settle_cnt   <= STW'(acz_pkg::SETTLE_CYCLES - 1);
      drain_cnt    <= '0;
      k            <= '0;
      issue_q      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      issue_q <= issue_v;

      // Register writes.
      if (cfg_acc) begin
        case (cfg_index)
          acz_pkg::CFG_AXIS:   cfg_axis   <= cfg_data[1:0];
          acz_pkg::CFG_RADIUS: cfg_radius <= cfg_data[3:0];
          acz_pkg::CFG_SIZE_X: cfg_size_x <= cfg_data[5:0];
          acz_pkg::CFG_SIZE_Y: cfg_size_y <= cfg_data[5:0];
          acz_pkg::CFG_SIZE_Z: cfg_size_z <= cfg_data[6:0];
          default: ;
        endcase
      end

      case (state)
        acz_pkg::S_SETTLE: begin
          if ((settle_cnt != '0) && !cfg_acc) begin
            settle_cnt <= settle_cnt - STW'(1);
          end
        end
        acz_pkg::S_DIVZ_WAIT: begin
          if (div_done) begin
            oz <= div_quotient;
          end
        end
        acz_pkg::S_DIVY_WAIT: begin
          if (div_done) begin
            oy <= YW'(div_quotient);
            ox <= XW'(div_remainder);
          end
        end
        acz_pkg::S_DECODE: begin
          // A voxel after a finished volume opens a new one.
          if ((item.mode == acz_pkg::MODE_VOXEL) && (outputs_sent >= total_q)) begin
            inputs_seen  <= '0;
            outputs_sent <= '0;
            in_ptr       <= '0;
            out_ptr      <= '0;
            ox           <= '0;
            oy           <= '0;
            oz           <= '0;
          end
        end
        acz_pkg::S_WRITE: begin
          if (ring_we) begin
            inputs_seen <= inputs_seen + CW'(1);
            in_ptr      <= (in_ptr == RAW'(RING_DEPTH - 1)) ? '0 : in_ptr + RAW'(1);
          end
        end
        acz_pkg::S_START: begin
          k         <= '0;
          drain_cnt <= '0;
        end
        acz_pkg::S_MAC: begin
          k <= k + TAW'(1);
        end
        acz_pkg::S_DRAIN: begin
          drain_cnt <= drain_cnt + DRW'(1);
        end
        acz_pkg::S_OUT: begin
          if (out_load) begin
            outputs_sent <= outputs_sent + CW'(1);
            out_ptr      <= (out_ptr == RAW'(RING_DEPTH - 1)) ? '0 : out_ptr + RAW'(1);
            // Step the output position in raster order.
            if ((ox + XW'(1)) == sx_e) begin
              ox <= '0;
              if ((oy + YW'(1)) == sy_e) begin
                oy <= '0;
                oz <= oz + CW'(1);
              end else begin
                oy <= oy + YW'(1);
              end
            end else begin
              ox <= ox + XW'(1);
            end
          end
        end
        default: ;
      endcase

      if (cfg_acc) begin
        settle_cnt <= STW'(acz_pkg::SETTLE_CYCLES - 1);
      end

      // Output word register.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: derived sizes, held word, addresses and result.
  always_ff @(posedge clk) begin
    plane_q <= PW'(sx_e) * PW'(sy_e);
    case (axis_e)
      acz_pkg::AXIS_Z: stride_q <= plane_q;
      acz_pkg::AXIS_Y: stride_q <= PW'(sx_e);
      default:         stride_q <= PW'(1);
    endcase
    lag_q   <= LW'(rad_e) * LW'(stride_q);
    total_q <= CW'(plane_q) * CW'(sz_e);

    if (in_acc) begin
      item <= in_data;
    end

    case (state)
      acz_pkg::S_START: begin
        addr <= base_addr;
        rel  <= {2'b00, pos_c} - RLW'(rad_e);
      end
      acz_pkg::S_MAC: begin
        addr <= step_addr;
        rel  <= rel + RLW'(1);
      end
      default: ;
    endcase

    if (out_load) begin
      out_data.out_value  <= mac_result;
      out_data.last_voxel <= last_c;
    end
  end

  acz_div #(
    .DW(CW),
    .VW(PW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  acz_mem #(
    .RING_DEPTH (RING_DEPTH),
    .RAW        (RAW),
    .TAP_COUNT  (TAP_COUNT),
    .TAW        (TAW)
  ) u_mem (
    .clk        (clk),
    .rst        (rst),
    .ring_we    (ring_we),
    .ring_waddr (in_ptr),
    .ring_wdata (item.sample_value),
    .ring_raddr (addr),
    .ring_rdata (ring_rdata),
    .tap_we     (tap_we),
    .tap_waddr  (TAW'(item.tap_index)),
    .tap_wdata  (item.sample_value),
    .tap_raddr  (k),
    .tap_rdata  (tap_rdata)
  );

  acz_mac #(
    .AW(AW)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .sample (ring_rdata),
    .tap    (tap_rdata),
    .result (mac_result)
  );

endmodule

`default_nettype wire

// ===== design/acz_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module acz_div #(
  parameter int DW = 17,
  parameter int VW = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient,
  output logic [VW-1:0]      remainder
);

  localparam int NW = $clog2(DW + 1);

  logic [DW-1:0] quo;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [NW-1:0] cnt;
  logic          run;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    trial = {rem, quo[DW-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= NW'(DW);
      end else if (run) begin
        cnt <= cnt - NW'(1);
        if (cnt == NW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (run) begin
      quo <= DW'({quo, fits});
      rem <= fits ? VW'(diff) : VW'(trial);
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

// ===== design/acz_mac.sv =====
// Shared multiply-accumulate unit with round-to-nearest and saturation to Q0.16.
`default_nettype none

module acz_mac #(
  parameter int AW = 37
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire acz_pkg::mac_ctrl_t ctrl,
  input  wire logic [15:0]       sample,
  input  wire logic [15:0]       tap,
  output logic [15:0]            result
);

  logic [31:0]   prod_q;
  logic          pv_q;
  logic [AW-1:0] acc;
  logic [AW:0]   sum_r;

  // Product stage flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctrl.en;
    end
  end

  // Product register, then accumulate.
  always_ff @(posedge clk) begin
    prod_q <= sample * tap;
    if (ctrl.clear) begin
      acc <= '0;
    end else if (pv_q) begin
      acc <= acc + AW'(prod_q);
    end
  end

  // Round half up to Q0.16 and saturate.
  always_comb begin
    sum_r = {1'b0, acc} + (AW + 1)'(32'h0000_8000);
    if (|sum_r[AW:32]) begin
      result = 16'hFFFF;
    end else begin
      result = sum_r[31:16];
    end
  end

endmodule

`default_nettype wire

// ===== design/acz_mem.sv =====
// Sample ring memory and kernel tap memory, both with registered read data.
`default_nettype none

module acz_mem #(
  parameter int RING_DEPTH = 16385,
  parameter int RAW        = 15,
  parameter int TAP_COUNT  = 17,
  parameter int TAW        = 5
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           ring_we,
  input  wire logic [RAW-1:0] ring_waddr,
  input  wire logic [15:0]    ring_wdata,
  input  wire logic [RAW-1:0] ring_raddr,
  output logic [15:0]         ring_rdata,
  input  wire logic           tap_we,
  input  wire logic [TAW-1:0] tap_waddr,
  input  wire logic [15:0]    tap_wdata,
  input  wire logic [TAW-1:0] tap_raddr,
  output logic [15:0]         tap_rdata
);

  logic [15:0]          ring [RING_DEPTH];
  logic [15:0]          taps [TAP_COUNT];
  logic [TAP_COUNT-1:0] tap_valid;
  logic [15:0]          tap_q;
  logic                 tap_vq;

  // Sample ring: one write and one read port.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_waddr] <= ring_wdata;
    end
    ring_rdata <= ring[ring_raddr];
  end

  // Kernel taps: data store.
  always_ff @(posedge clk) begin
    if (tap_we) begin
      taps[tap_waddr] <= tap_wdata;
    end
    tap_q <= taps[tap_raddr];
  end

  // Kernel taps: written flags, so that an unwritten tap reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_valid <= '0;
      tap_vq    <= 1'b0;
    end else begin
      if (tap_we) begin
        tap_valid[tap_waddr] <= 1'b1;
      end
      tap_vq <= tap_valid[tap_raddr];
    end
  end

  assign tap_rdata = tap_vq ? tap_q : 16'h0000;

endmodule

`default_nettype wire

// ===== design/acz_checker.sv =====
// Port-level checks on the axis convolution block, bound to the top level.
`default_nettype none

module acz_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire acz_pkg::out_t out_data,
  input wire logic          cfg_valid,
  input wire logic          cfg_ready
);

  // A stalled output word stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // One word at a time: after an accepted word the input is stalled.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a word is in progress");

  // A register write is followed by the settle sequence.
  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> in_stall)
    else $error("input not stalled after a register write");

  // A new output word only appears while the input side is busy.
  a_word_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output word appeared without work in progress");

endmodule

bind axis_convolution_zero_pad_top acz_checker u_acz_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
